/* rtl/mmce_pkg.sv */
// mmce_pkg: shared types, mode codes and crc helper for the checksum engine
// no dependencies; used by the datapath, the top level and the testbench
`default_nettype none

package mmce_pkg;

	// mode register codes
	localparam logic [2:0] MODE_CRC16  = 3'd0;
	localparam logic [2:0] MODE_CRC32  = 3'd1;
	localparam logic [2:0] MODE_CRC32C = 3'd2;
	localparam logic [2:0] MODE_XOR8   = 3'd3;
	localparam logic [2:0] MODE_SUM16  = 3'd4;
	localparam logic [2:0] MODE_RESET  = MODE_CRC32;

	// reflected polynomials and initial values
	localparam logic [31:0] POLY_CRC16  = 32'h0000_8408;
	localparam logic [31:0] POLY_CRC32  = 32'hEDB8_8320;
	localparam logic [31:0] POLY_CRC32C = 32'h82F6_3B78;
	localparam logic [31:0] INIT_CRC16  = 32'h0000_FFFF;
	localparam logic [31:0] INIT_CRC32  = 32'hFFFF_FFFF;
	localparam logic [31:0] INIT_ZERO   = 32'h0000_0000;
	localparam int unsigned BITS_PER_BYTE = 8;

	// result widths in bytes
	localparam logic [2:0] WIDTH_ONE  = 3'd1;
	localparam logic [2:0] WIDTH_TWO  = 3'd2;
	localparam logic [2:0] WIDTH_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       no_byte;
		logic       last_item;
	} mmce_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic        open;
	} mmce_state_t;

	typedef struct packed {
		logic [31:0] checksum_value;
		logic [2:0]  width_bytes;
	} mmce_result_t;

	// one byte of a reflected crc, bit at a time (unrolls to xor logic)
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
		input logic [7:0] data, input logic [31:0] poly);
		logic [31:0] crc;
		crc = crc_in ^ {24'd0, data};
		for (int i = 0; i < BITS_PER_BYTE; i++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ poly;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage : mmce_pkg

`default_nettype wire

/* rtl/mmce_if.sv */
// mmce_if: valid/ready channel interfaces for items, results and the mode register
// no dependencies; the field widths are written out in the interfaces
`default_nettype none

interface mmce_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       no_byte;
	logic       last_item;

	modport source (output valid, output data_byte, output no_byte, output last_item,
		input ready);
	modport sink (input valid, input data_byte, input no_byte, input last_item,
		output ready);
endinterface : mmce_item_if

interface mmce_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] checksum_value;
	logic [2:0]  width_bytes;

	modport source (output valid, output checksum_value, output width_bytes, input ready);
	modport sink (input valid, input checksum_value, input width_bytes, output ready);
endinterface : mmce_result_if

interface mmce_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] wdata;

	modport source (output valid, output wdata, input ready);
	modport sink (input valid, input wdata, output ready);
endinterface : mmce_cfg_if

`default_nettype wire

/* rtl/mmce_datapath.sv */
// mmce_datapath: one-byte update and finish of the running checksum
// depends on mmce_pkg (mode codes, polynomials, crc_byte)
`default_nettype none

module mmce_datapath (
	input  wire logic [2:0]           mode,
	input  wire mmce_pkg::mmce_state_t state_cur,
	input  wire mmce_pkg::mmce_item_t  item,
	output mmce_pkg::mmce_state_t     state_next,
	output mmce_pkg::mmce_result_t    result
);
	import mmce_pkg::*;

	logic [2:0]  eff_mode;
	logic [31:0] init_value;
	logic [31:0] base_value;
	logic [31:0] upd_value;
	logic [31:0] new_value;

	// undefined codes fall back to crc32
	assign eff_mode = (mode > MODE_SUM16) ? MODE_CRC32 : mode;

	// start value of a fresh message
	always_comb begin
		case (eff_mode) inside
			MODE_CRC16:             init_value = INIT_CRC16;
			MODE_XOR8, MODE_SUM16:  init_value = INIT_ZERO;
			default:                init_value = INIT_CRC32;
		endcase
	end

	assign base_value = state_cur.open ? state_cur.value : init_value;

	// byte update per mode
	always_comb begin
		case (eff_mode)
			MODE_CRC16:  upd_value = crc_byte({16'd0, base_value[15:0]}, item.data_byte,
				POLY_CRC16) & 32'h0000_FFFF;
			MODE_CRC32C: upd_value = crc_byte(base_value, item.data_byte, POLY_CRC32C);
			MODE_XOR8:   upd_value = {24'd0, base_value[7:0] ^ item.data_byte};
			MODE_SUM16:  upd_value = {16'd0, base_value[15:0] + {8'd0, item.data_byte}};
			default:     upd_value = crc_byte(base_value, item.data_byte, POLY_CRC32);
		endcase
	end

	assign new_value = item.no_byte ? base_value : upd_value;

	// finish and width
	always_comb begin
		case (eff_mode)
			MODE_CRC16: begin
				result.checksum_value = {16'd0, ~new_value[15:0]};
				result.width_bytes    = WIDTH_TWO;
			end
			MODE_XOR8: begin
				result.checksum_value = {24'd0, new_value[7:0]};
				result.width_bytes    = WIDTH_ONE;
			end
			MODE_SUM16: begin
				result.checksum_value = {16'd0, new_value[15:0]};
				result.width_bytes    = WIDTH_TWO;
			end
			default: begin
				result.checksum_value = ~new_value;
				result.width_bytes    = WIDTH_FOUR;
			end
		endcase
	end

	// the last item closes the message; the next item reloads the start value
	assign state_next.value = item.last_item ? init_value : new_value;
	assign state_next.open  = ~item.last_item;

endmodule : mmce_datapath

`default_nettype wire

/* rtl/multi_mode_checksum_engine.sv */
// multi_mode_checksum_engine: top level with input register, state and result register
// depends on mmce_pkg, mmce_if and mmce_datapath
`default_nettype none

// Takes at most one message byte per request and returns one checksum per message, on the
// request marked last. The mode register picks crc16 x25, crc32, crc32c, xor8 or
// sum16; codes 5 to 7 act as crc32. Write the mode only with no request in flight;
// a change inside a message applies the new mode to the running value as it stands.
// Throughput is one request per clock while no last request waits on a full result
// register; the byte update is eight unrolled xor steps between the input register
// and the running-value register, and that path sets the clock. A result is valid
// on the result channel from the edge at which its request leaves the input
// register. A waiting result blocks only a later last request; non-final requests
// keep flowing while it waits.

module multi_mode_checksum_engine (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mmce_item_if.sink     item_ch,
	mmce_result_if.source result_ch,
	mmce_cfg_if.sink      cfg_ch
);
	import mmce_pkg::*;

	logic [2:0]   mode_q;
	mmce_item_t   item_s1;
	logic         valid_s1;
	mmce_state_t  state_q;
	mmce_state_t  state_next;
	mmce_result_t result_next;
	mmce_result_t result_q;
	logic         res_valid_q;
	logic         adv_s1;
	logic         take_in;

	// mode register, always ready
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_ch.valid) begin
			mode_q <= cfg_ch.wdata;
		end
	end

	// handshake: the stage moves unless a last request meets a full result register that is not taken
	assign adv_s1        = valid_s1 && (!item_s1.last_item || !res_valid_q || result_ch.ready);
	assign item_ch.ready = !valid_s1 || adv_s1;
	assign take_in       = item_ch.valid && item_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.data_byte <= item_ch.data_byte;
			item_s1.no_byte   <= item_ch.no_byte;
			item_s1.last_item <= item_ch.last_item;
		end
	end

	mmce_datapath u_datapath (
		.mode       (mode_q),
		.state_cur  (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	// running value and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.value <= INIT_CRC32;
			state_q.open  <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_item) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_item) begin
			result_q <= result_next;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.checksum_value = result_q.checksum_value;
	assign result_ch.width_bytes    = result_q.width_bytes;

endmodule : multi_mode_checksum_engine

`default_nettype wire

/* rtl/mmce_checker.sv */
// mmce_checker: port-level checks on the result channel, bound to the top level
// depends only on the top level's ports
`default_nettype none

module mmce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] checksum_value,
	input wire logic [2:0]  width_bytes
);

	// a pending result holds until taken
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	// a stalled result keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(checksum_value) && $stable(width_bytes))
		else $error("stalled result changed");

	// width is one of the legal sizes
	a_width_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (width_bytes == 3'd1 || width_bytes == 3'd2 || width_bytes == 3'd4))
		else $error("illegal result width");

	// unused upper bytes of a narrow checksum are zero
	a_narrow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((width_bytes != 3'd1 || checksum_value[31:8] == 24'd0) &&
			(width_bytes != 3'd2 || checksum_value[31:16] == 16'd0)))
		else $error("narrow checksum has upper bits set");

endmodule : mmce_checker

bind multi_mode_checksum_engine mmce_checker u_mmce_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result_ch.valid),
	.res_ready      (result_ch.ready),
	.checksum_value (result_ch.checksum_value),
	.width_bytes    (result_ch.width_bytes)
);

`default_nettype wire

/* tb/multi_mode_checksum_engine_tb.sv */
// multi_mode_checksum_engine_tb: checks the multi-mode checksum engine request by request
// depends on mmce_pkg, mmce_if and the engine top level; a predictor class holds the expected
// checksums, plain tasks drive message bytes and mode writes, an initial block drives result back-pressure
`timescale 1ns / 100ps

module multi_mode_checksum_engine_tb;
	import mmce_pkg::*;

	// undefined mode codes, handled by the engine as crc32
	localparam logic [2:0] MODE_UNDEF_5 = 3'd5;
	localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
	localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 100;
	localparam int MAX_REPORTS   = 50;

	// expected checksums per message, kept in arrival order
	class checksum_scoreboard;
		localparam logic [31:0] X25_POLY   = 32'h0000_8408;
		localparam logic [31:0] IEEE_POLY  = 32'hEDB8_8320;
		localparam logic [31:0] CASTAG_POLY = 32'h82F6_3B78;

		logic [2:0]   mode_reg;
		logic [31:0]  running;
		bit           open;
		mmce_result_t checksum_q[$];
		int           errors;

		function new();
			mode_reg = MODE_RESET;
			running  = 32'hFFFF_FFFF;
			open     = 1'b0;
			errors   = 0;
		endfunction

		function void set_mode(input logic [2:0] m);
			mode_reg = m;
		endfunction

		function int pending();
			return checksum_q.size();
		endfunction

		function logic [2:0] active_mode();
			return (mode_reg > MODE_SUM16) ? MODE_CRC32 : mode_reg;
		endfunction

		function logic [31:0] start_value(input logic [2:0] m);
			case (m) inside
				MODE_CRC16: return 32'h0000_FFFF;
				MODE_XOR8, MODE_SUM16: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		endfunction

		// reflected crc over one byte, lsb first
		function logic [31:0] reflect_crc(input logic [31:0] v, input logic [7:0] b,
			input logic [31:0] poly);
			logic [31:0] r;
			r = v ^ {24'd0, b};
			for (int k = 0; k < 8; k++)
				r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
			return r;
		endfunction

		function void note_request(input mmce_item_t it);
			logic [2:0]   m;
			logic [31:0]  t;
			mmce_result_t res;
			m = active_mode();
			if (!open)
				running = start_value(m);
			open = 1'b1;
			// fold the byte into the running value
			if (!it.no_byte) begin
				case (m)
					MODE_CRC16: begin
						t = reflect_crc({16'd0, running[15:0]}, it.data_byte, X25_POLY);
						running = {16'd0, t[15:0]};
					end
					MODE_CRC32C: running = reflect_crc(running, it.data_byte, CASTAG_POLY);
					MODE_XOR8: running = {24'd0, running[7:0] ^ it.data_byte};
					MODE_SUM16: begin
						t = running + {24'd0, it.data_byte};
						running = {16'd0, t[15:0]};
					end
					default: running = reflect_crc(running, it.data_byte, IEEE_POLY);
				endcase
			end
			// close the message and queue its checksum
			if (it.last_item) begin
				case (m)
					MODE_CRC16: begin
						res.checksum_value = {16'd0, ~running[15:0]};
						res.width_bytes    = WIDTH_TWO;
					end
					MODE_XOR8: begin
						res.checksum_value = {24'd0, running[7:0]};
						res.width_bytes    = WIDTH_ONE;
					end
					MODE_SUM16: begin
						res.checksum_value = {16'd0, running[15:0]};
						res.width_bytes    = WIDTH_TWO;
					end
					default: begin
						res.checksum_value = ~running;
						res.width_bytes    = WIDTH_FOUR;
					end
				endcase
				checksum_q = {checksum_q, res};
				running = start_value(m);
				open    = 1'b0;
			end
		endfunction

		task report(input string msg);
			if (errors < MAX_REPORTS)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(input logic [31:0] value, input logic [2:0] width);
			mmce_result_t want;
			if (checksum_q.size() == 0) begin
				report($sformatf("unexpected result %h width %0d", value, width));
			end else begin
				want = checksum_q.pop_front();
				if (value !== want.checksum_value)
					report($sformatf("checksum %h, expected %h", value, want.checksum_value));
				if (width !== want.width_bytes)
					report($sformatf("width %0d, expected %0d", width, want.width_bytes));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mmce_item_if   item_ch ();
	mmce_result_if result_ch ();
	mmce_cfg_if    cfg_ch ();

	multi_mode_checksum_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	checksum_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;
	int items_sent    = 0;
	int quiet_cycles  = 0;

	// clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// result side: random back-pressure with an occasional long hold-off
	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready = 1'b0;
			end else begin
				result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.checksum_value, result_ch.width_bytes);
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request, called and returning at a falling edge
	task send_request(input mmce_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid     = 1'b1;
		item_ch.data_byte = it.data_byte;
		item_ch.no_byte   = it.no_byte;
		item_ch.last_item = it.last_item;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_request(it);
		items_sent++;
		@(negedge clk);
	endtask

	task send_fields(input logic [7:0] b, input logic nob, input logic last);
		mmce_item_t it;
		it.data_byte = b;
		it.no_byte   = nob;
		it.last_item = last;
		send_request(it);
	endtask

	// a message of len requests (one byteless request when len is 0) with random bytes, some of them byteless
	task send_message(input int len, input bit close);
		logic [7:0] b;
		if (len == 0) begin
			send_fields(8'($urandom), 1'b1, close);
		end else begin
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(15))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(255));
				endcase
				send_fields(b, ($urandom_range(9) == 0), close && (i == len - 1));
			end
		end
	endtask

	// block is idle: nothing in flight, every checksum back
	task wait_idle();
		item_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_mode(input logic [2:0] m);
		wait_idle();
		cfg_ch.wdata = m;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_mode(m);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// random messages, sometimes leaving the last one open across the mode change
	task run_phase(input int count);
		int start;
		int len;
		start = items_sent;
		while (items_sent - start < count) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(6);
			send_message(len, 1'b1);
		end
		if ($urandom_range(1))
			send_message($urandom_range(1, 3), 1'b0);
	endtask

	initial begin
		logic [2:0] phase_modes [9];
		phase_modes = '{MODE_CRC16, MODE_XOR8, MODE_SUM16, MODE_CRC32C, MODE_UNDEF_7,
			MODE_CRC32, MODE_UNDEF_5, MODE_UNDEF_6, MODE_CRC16};

		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.data_byte = 8'h00;
		item_ch.no_byte   = 1'b0;
		item_ch.last_item = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.wdata      = MODE_RESET;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 75;

		// reset mode: empty message, byte extremes, byteless opener inside a message
		send_fields(8'h3C, 1'b1, 1'b1);
		send_fields(8'h00, 1'b0, 1'b1);
		send_fields(8'hFF, 1'b0, 1'b1);
		send_fields(8'hFF, 1'b1, 1'b0);
		send_fields(8'h5A, 1'b0, 1'b0);
		send_fields(8'h00, 1'b1, 1'b0);
		send_fields(8'hC3, 1'b0, 1'b1);

		// crc16, crc32c, xor8 and sum16 in turn: empty message then two extreme bytes
		foreach (phase_modes[i]) begin
			if (i < 4) begin
				write_mode(phase_modes[i] == MODE_CRC16 ? MODE_CRC16 :
					(i == 1) ? MODE_CRC32C : (i == 2) ? MODE_XOR8 : MODE_SUM16);
				send_fields(8'hA5, 1'b1, 1'b1);
				send_fields(8'hFF, 1'b0, 1'b0);
				send_fields(8'h00, 1'b0, 1'b1);
			end
		end

		// mode change inside an open sum16 message
		send_fields(8'h80, 1'b0, 1'b0);
		send_fields(8'h7F, 1'b0, 1'b0);
		write_mode(MODE_CRC16);
		send_fields(8'h01, 1'b0, 1'b1);

		// undefined codes act as crc32
		write_mode(MODE_UNDEF_7);
		send_fields(8'h31, 1'b0, 1'b1);
		write_mode(MODE_UNDEF_5);
		send_fields(8'h00, 1'b1, 1'b1);

		// random phases, idling pattern changes every three phases
		foreach (phase_modes[p]) begin
			write_mode(phase_modes[p]);
			case (p / 3)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// long result hold-off while short messages keep coming
			if (p == 6) begin
				stall_request = 1'b1;
				for (int k = 0; k < 30; k++)
					send_message($urandom_range(1), 1'b1);
			end
			run_phase(PHASE_ITEMS);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
